/* design/pseq_pkg.sv */
// shared constants and types for the pair-sum existence query block
`default_nettype none

package pseq_pkg;

	localparam int PSEQ_MAX_ENTRIES = 1024;
	localparam int VAL_W            = 32;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic valid;
		logic found;
	} pseq_result_t;

endpackage

`default_nettype wire

/* design/pseq_ram.sv */
// generic single-write, dual-read synchronous ram with registered read data
`default_nettype none

module pseq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    wa,
	input  wire logic [WIDTH-1:0] wd,
	input  wire logic [AW-1:0]    ra,
	input  wire logic [AW-1:0]    rb,
	output logic      [WIDTH-1:0] qa,
	output logic      [WIDTH-1:0] qb
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		qa <= mem[ra];
		qb <= mem[rb];
	end

endmodule

`default_nettype wire

/* design/pseq_engine.sv */
// sorted-insert and two-pointer query sequencer around the value store
`default_nettype none

module pseq_engine #(
	parameter int MAX_ENTRIES = pseq_pkg::PSEQ_MAX_ENTRIES
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic                                opcode,
	input  wire logic signed [pseq_pkg::VAL_W-1:0]   operand,
	input  wire logic                                res_free,
	output logic                                     idle,
	output pseq_pkg::pseq_result_t                   res
);

	import pseq_pkg::*;

	localparam int AW    = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_INS  = 5'b00010,
		S_PUT  = 5'b00100,
		S_QRY  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [AW-1:0]      idx_q, idx_d;
	logic [AW-1:0]      lo_q, lo_d;
	logic [AW-1:0]      hi_q, hi_d;
	logic signed [VAL_W-1:0] val_q, val_d;
	logic               found_q, found_d;

	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [VAL_W-1:0]   mem_wd;
	logic [AW-1:0]      mem_ra, mem_rb;
	logic [VAL_W-1:0]   mem_qa, mem_qb;

	logic [CNT_W-1:0]   cnt_m1;
	logic [AW-1:0]      lo_inc, hi_dec, idx_inc, idx_dec;
	logic signed [VAL_W:0] pair_sum, target;

	pseq_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk(clk),
		.we (mem_we),
		.wa (mem_wa),
		.wd (mem_wd),
		.ra (mem_ra),
		.rb (mem_rb),
		.qa (mem_qa),
		.qb (mem_qb)
	);

	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign lo_inc   = lo_q + AW'(1);
	assign hi_dec   = hi_q - AW'(1);
	assign idx_inc  = idx_q + AW'(1);
	assign idx_dec  = idx_q - AW'(1);
	assign pair_sum = $signed({mem_qa[VAL_W-1], mem_qa}) + $signed({mem_qb[VAL_W-1], mem_qb});
	assign target   = {val_q[VAL_W-1], val_q};

	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		val_d   = val_q;
		found_d = found_q;
		mem_we  = 1'b0;
		mem_wa  = idx_inc;
		mem_wd  = val_q;
		mem_ra  = lo_q;
		mem_rb  = hi_q;
		res     = '{valid: 1'b0, found: found_q};
		case (state_q)
			S_IDLE: begin
				mem_ra = {AW{1'b0}};
				mem_rb = cnt_m1[AW-1:0];
				if (start) begin
					val_d = operand;
					if (opcode == OP_LOAD) begin
						if (cnt_q == CNT_W'(0)) begin
							mem_we = 1'b1;
							mem_wa = {AW{1'b0}};
							mem_wd = operand;
							cnt_d  = cnt_q + CNT_W'(1);
						end else if (cnt_q != CNT_W'(MAX_ENTRIES)) begin
							// walk down from the top entry, shifting larger values up
							idx_d   = cnt_m1[AW-1:0];
							mem_ra  = cnt_m1[AW-1:0];
							state_d = S_INS;
						end
					end else begin
						lo_d = {AW{1'b0}};
						hi_d = cnt_m1[AW-1:0];
						if (cnt_q < CNT_W'(2)) begin
							found_d = 1'b0;
							state_d = S_FIN;
						end else begin
							state_d = S_QRY;
						end
					end
				end
			end
			S_INS: begin
				// read of idx-1 runs ahead of the write to idx+1, so no overlap
				mem_ra = idx_dec;
				mem_we = 1'b1;
				mem_wa = idx_inc;
				if ($signed(mem_qa) > val_q) begin
					mem_wd = mem_qa;
					if (idx_q == {AW{1'b0}}) begin
						state_d = S_PUT;
					end else begin
						idx_d = idx_dec;
					end
				end else begin
					mem_wd  = val_q;
					cnt_d   = cnt_q + CNT_W'(1);
					state_d = S_IDLE;
				end
			end
			S_PUT: begin
				mem_we  = 1'b1;
				mem_wa  = {AW{1'b0}};
				mem_wd  = val_q;
				cnt_d   = cnt_q + CNT_W'(1);
				state_d = S_IDLE;
			end
			S_QRY: begin
				if (pair_sum == target) begin
					found_d = 1'b1;
					state_d = S_FIN;
				end else if (lo_inc == hi_q) begin
					// pointers meet whichever one moves
					found_d = 1'b0;
					state_d = S_FIN;
				end else if (pair_sum < target) begin
					lo_d   = lo_inc;
					mem_ra = lo_inc;
				end else begin
					hi_d   = hi_dec;
					mem_rb = hi_dec;
				end
			end
			S_FIN: begin
				if (res_free) begin
					res.valid = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		val_q   <= val_d;
		found_q <= found_d;
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond capacity");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("entry count moved by other than one");

	a_qry_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_QRY |-> lo_q < hi_q && CNT_W'(hi_q) < cnt_q)
		else $error("query pointers out of order");

	a_ins_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS |-> CNT_W'(idx_q) < cnt_q && cnt_q < CNT_W'(MAX_ENTRIES))
		else $error("insert walk outside filled entries");
`endif

endmodule

`default_nettype wire

/* design/pair_sum_existence_query.sv */
// Pair-sum existence query. Load transactions (opcode 0) insert a signed
// 32-bit value into a store kept in ascending order in a dual-read ram;
// loads past MAX_ENTRIES are dropped and loads give no result. A query
// transaction (opcode 1) walks the store with two pointers, one step per
// cycle off the ram's two read ports, and returns one pair_found result.
// A load into an empty store is written directly and a load into a full
// store is dropped; otherwise each entry larger than the value is shifted
// up one place, one entry per cycle through the single write port, before
// the value is written. A query's result is registered once a pair is
// found or the pointers meet, and waits while the output register still
// holds a stalled result. One transaction is worked on at a time; the
// next is accepted in the cycle after the previous one finishes, while an
// earlier result may still sit in the output register.
// The store needs no clearing after reset: only values from the first
// entry_count entries are ever used.
`default_nettype none

module pair_sum_existence_query #(
	parameter int MAX_ENTRIES = pseq_pkg::PSEQ_MAX_ENTRIES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              item_valid,
	output logic                                   item_stall,
	input  wire logic                              opcode,
	input  wire logic signed [pseq_pkg::VAL_W-1:0] operand,
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output logic                                   pair_found
);

	import pseq_pkg::*;

	logic         idle;
	logic         res_free;
	pseq_result_t res;
	logic         result_valid_q;
	logic         pair_found_q;

	assign item_stall   = !idle;
	assign res_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign pair_found   = pair_found_q;

	pseq_engine #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (item_valid && idle),
		.opcode  (opcode),
		.operand (operand),
		.res_free(res_free),
		.idle    (idle),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res.valid) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			pair_found_q <= res.found;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(result_valid_q && result_stall))
		else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

/* dv/pair_sum_existence_query_test.sv */
// self-checking testbench for the pair-sum existence query block
`default_nettype none

module pair_sum_existence_query_test;
	import pseq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ENTRIES   = PSEQ_MAX_ENTRIES;
	localparam int N_RANDOM    = 400;
	localparam int IDLE_PCT    = 28;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_WAIT  = 2 * N_ENTRIES + 16;

	localparam logic signed [VAL_W-1:0] V_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] V_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic                    op;
		logic signed [VAL_W-1:0] val;
	} pending_item_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    item_valid = 1'b0;
	logic                    item_stall;
	logic                    opcode = OP_LOAD;
	logic signed [VAL_W-1:0] operand = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic                    pair_found;

	pending_item_t           pending_ops[$];
	pending_item_t           next_op;
	logic signed [VAL_W-1:0] loaded_vals[$];	// what the generator has put in the store
	logic                    expected_found[$];
	logic signed [VAL_W-1:0] sorted_vals[N_ENTRIES];
	int                      sorted_count = 0;
	int                      items_taken = 0;
	int                      idle_cycles = 0;
	int                      errors = 0;
	logic                    expect_now;
	logic                    calm;

	pair_sum_existence_query dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.operand      (operand),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pair_found   (pair_found)
	);

	always #2 clk = ~clk;

	// no idling on either side across a run of transactions in the random part
	assign calm = (items_taken >= 150) && (items_taken < 260);

	function automatic void insert_sorted_value(input logic signed [VAL_W-1:0] v);
		int pos;
		if (sorted_count >= N_ENTRIES) return;
		pos = 0;
		while (pos < sorted_count && sorted_vals[pos] <= v) pos++;
		for (int k = sorted_count; k > pos; k--) sorted_vals[k] = sorted_vals[k-1];
		sorted_vals[pos] = v;
		sorted_count++;
	endfunction

	// two pointers over the sorted store, sums held at 33 bits
	function automatic logic has_pair_sum(input logic signed [VAL_W-1:0] target);
		int                    lo;
		int                    hi;
		logic signed [VAL_W:0] s;
		logic signed [VAL_W:0] t;
		t  = {target[VAL_W-1], target};
		lo = 0;
		hi = sorted_count - 1;
		while (lo < hi) begin
			s = {sorted_vals[lo][VAL_W-1], sorted_vals[lo]}
				+ {sorted_vals[hi][VAL_W-1], sorted_vals[hi]};
			if (s == t) return 1'b1;
			if (s < t) lo++;
			else hi--;
		end
		return 1'b0;
	endfunction

	function automatic void push_op(input logic op, input logic signed [VAL_W-1:0] v);
		pending_item_t it;
		it.op  = op;
		it.val = v;
		pending_ops.insert(pending_ops.size(), it);
		if (op == OP_LOAD && loaded_vals.size() < N_ENTRIES)
			loaded_vals.insert(loaded_vals.size(), v);
	endfunction

	function automatic logic signed [VAL_W-1:0] extreme_value();
		case ($urandom_range(5))
			0: begin
				return V_MIN;
			end
			1: begin
				return V_MAX;
			end
			2: begin
				return V_MIN + 1;
			end
			3: begin
				return V_MAX - 1;
			end
			4: begin
				return '0;
			end
			default: begin
				return -1;
			end
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 40) return int'($urandom_range(32)) - 16;
		if (r < 50) return extreme_value();
		return $urandom;
	endfunction

	// up to half the targets are sums of two stored entries, so hits are common
	function automatic logic signed [VAL_W-1:0] pick_target();
		int                    r;
		int                    i;
		int                    j;
		logic signed [VAL_W:0] s;
		r = $urandom_range(99);
		if (r < 50 && loaded_vals.size() >= 2) begin
			i = $urandom_range(loaded_vals.size() - 1);
			j = $urandom_range(loaded_vals.size() - 2);
			if (j >= i) j++;
			s = {loaded_vals[i][VAL_W-1], loaded_vals[i]}
				+ {loaded_vals[j][VAL_W-1], loaded_vals[j]};
			if (s[VAL_W] == s[VAL_W-1]) return s[VAL_W-1:0];
			return $urandom;
		end
		if (r < 70) return int'($urandom_range(64)) - 32;
		if (r < 80) return extreme_value();
		return $urandom;
	endfunction

	// driver: holds a stalled transaction, otherwise takes the next one or idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				items_taken <= items_taken + 1;
				if (opcode == OP_LOAD) insert_sorted_value(operand);
				else expected_found.insert(expected_found.size(), has_pair_sum(operand));
			end
			if (!item_valid || !item_stall) begin
				if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					next_op = pending_ops.pop_front();
					item_valid <= 1'b1;
					opcode     <= next_op.op;
					operand    <= next_op.val;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transaction against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_found.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none actual pair_found=%b",
						$realtime, pair_found);
				end else begin
					expect_now = expected_found.pop_front();
					if (pair_found !== expect_now) begin
						errors++;
						$display("%0t: pair_found expected %b actual %b",
							$realtime, expect_now, pair_found);
					end
				end
			end
			result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $realtime, idle_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		// directed: empty and single-entry store, equal values, extremes, 33-bit sums
		push_op(OP_QUERY, '0);
		push_op(OP_LOAD, 5);
		push_op(OP_QUERY, 10);
		push_op(OP_LOAD, 5);
		push_op(OP_QUERY, 10);
		push_op(OP_QUERY, 11);
		push_op(OP_LOAD, V_MIN);
		push_op(OP_LOAD, V_MAX);
		push_op(OP_QUERY, -1);
		push_op(OP_QUERY, V_MIN + 5);
		push_op(OP_QUERY, '0);
		push_op(OP_LOAD, '0);
		push_op(OP_QUERY, V_MIN);
		push_op(OP_LOAD, V_MAX);
		push_op(OP_QUERY, -2);	// max + max only matches if the sum wraps
		push_op(OP_QUERY, V_MAX);
		push_op(OP_LOAD, V_MIN);
		push_op(OP_QUERY, '0);	// min + min likewise
		push_op(OP_LOAD, -5);
		push_op(OP_QUERY, '0);

		for (int n = 0; n < N_RANDOM; n++) begin
			if ($urandom_range(99) < 60) push_op(OP_LOAD, pick_value());
			else push_op(OP_QUERY, pick_target());
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || item_valid || expected_found.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
